FILE: design/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
`default_nettype none
package mtep_pkg;
   localparam int DEF_TRACKS    = 16;
   localparam int DIV_W         = 15;
   localparam int MULT_W        = 28;
   localparam logic [DIV_W-1:0] DEF_DIVISION = 15'd96;

   localparam logic [2:0] KIND_TWO_DATA = 3'd0;
   localparam logic [2:0] KIND_ONE_DATA = 3'd1;
   localparam logic [2:0] KIND_TEMPO    = 3'd2;
   localparam logic [2:0] KIND_EOT      = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;

   localparam logic [2:0] REG_DIVISION = 3'd0;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  track;
      logic [7:0]  status;
      logic [6:0]  data1;
      logic [6:0]  data2;
      logic [31:0] tick;
      logic [23:0] tempo;
   } ev_type;
endpackage
`default_nettype wire

FILE: design/midi_track_event_parser_unit.sv
// An event is queued on its last byte, then loaded into the output register.
// Tempo events pass through the bit-serial tick_mult divider on the way.
// Throughput: one byte per cycle; req stalls only while the two-entry event
// queue is full, which happens during a tempo divide or while rsp is held off.
// Reset clears all per-track parse state and sets division to 96.
`default_nettype none
module midi_track_event_parser_unit
   import mtep_pkg::*;
#(
   parameter int TRACKS = DEF_TRACKS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // byte_in
   input  wire logic [4:0]   req_tuser,   // track[3:0], first_of_track[4]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // event_track, status_byte, first_data, second_data, event_tick, tempo_us, tick_mult
   output logic [111:0]      rsp_tdata,
   output logic [2:0]        rsp_tuser,   // event_kind
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   logic [DIV_W-1:0]  division_ff;
   logic              beat, push, pop, not_empty, has_room;
   ev_type            push_ev, head, out_ev;
   logic [MULT_W-1:0] out_mult;

   // register index sits at paddr[2]
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_DIVISION[0]) ? {17'd0, division_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) division_ff <= DEF_DIVISION;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_DIVISION[0])
         division_ff <= csr_pwdata[DIV_W-1:0];
   end

   assign req_tready = has_room;
   assign beat       = req_tvalid && has_room;

   mtep_front #(.TRACKS(TRACKS)) u_front (
      .clock(clock), .reset(reset), .in_beat(beat),
      .in_track(req_tuser[3:0]), .in_first(req_tuser[4]), .in_byte(req_tdata),
      .ev_push(push), .ev_data(push_ev));

   mtep_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_data(push_ev),
      .pop(pop), .not_empty(not_empty), .has_room(has_room), .head(head));

   mtep_back u_back (
      .clock(clock), .reset(reset), .division(division_ff),
      .q_valid(not_empty), .q_head(head), .q_pop(pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_ev(out_ev), .out_mult(out_mult));

   assign rsp_tuser = out_ev.kind;
   assign rsp_tdata = {2'b00, out_mult, out_ev.tempo, out_ev.tick, out_ev.data2,
                       out_ev.data1, out_ev.status, out_ev.track};
endmodule
`default_nettype wire

FILE: design/mtep_front.sv
// Front end: per-track byte parser, emits classified events.
`default_nettype none
module mtep_front
   import mtep_pkg::*;
#(
   parameter int TRACKS = DEF_TRACKS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_beat,
   input  wire logic [3:0]   in_track,
   input  wire logic         in_first,
   input  wire logic [7:0]   in_byte,
   output logic              ev_push,
   output ev_type            ev_data
);
   localparam int IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

   typedef enum logic [2:0] {
      PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_TYPE, PH_LEN, PH_PAYLOAD, PH_ENDED
   } phase_type;

   phase_type   phase_ff  [TRACKS];
   logic [7:0]  rs_ff     [TRACKS];
   logic [7:0]  held_ff   [TRACKS];
   logic [31:0] lacc_ff   [TRACKS];
   logic [31:0] tick_ff   [TRACKS];
   logic [31:0] prem_ff   [TRACKS];
   logic [7:0]  meta_ff   [TRACKS];
   logic [23:0] tacc_ff   [TRACKS];

   logic [IW-1:0] idx;
   logic          in_range;
   phase_type     phase, phase_in;
   logic [7:0]    rs, rs_in, held, held_in, meta, meta_in;
   logic [31:0]   lacc, lacc_in, tick, tick_in, prem, prem_in, vlq, consumed;
   logic [23:0]   tacc, tacc_in;
   logic [6:0]    b7;
   logic          emit;
   logic [2:0]    kind;
   logic [7:0]    ev_status;
   logic [6:0]    d1, d2;
   logic [23:0]   ev_tempo;

   assign idx      = IW'(in_track);
   assign in_range = {28'd0, in_track} < 32'(TRACKS);
   assign b7       = in_byte[6:0];

   always_comb begin
      phase = in_first ? PH_DELTA : phase_ff[idx];
      rs    = in_first ? 8'd0  : rs_ff[idx];
      held  = in_first ? 8'd0  : held_ff[idx];
      lacc  = in_first ? 32'd0 : lacc_ff[idx];
      tick  = in_first ? 32'd0 : tick_ff[idx];
      prem  = in_first ? 32'd0 : prem_ff[idx];
      meta  = in_first ? 8'd0  : meta_ff[idx];
      tacc  = in_first ? 24'd0 : tacc_ff[idx];
      phase_in = phase; rs_in = rs; held_in = held; lacc_in = lacc;
      tick_in = tick; prem_in = prem; meta_in = meta; tacc_in = tacc;
      emit = 1'b0; kind = KIND_ERROR; ev_status = 8'd0; d1 = 7'd0; d2 = 7'd0;
      ev_tempo = 24'd0;
      vlq      = {lacc[24:0], b7};
      consumed = lacc - prem;
      case (phase)
         PH_DELTA: begin
            lacc_in = vlq;
            if (!in_byte[7]) begin
               tick_in  = tick + vlq;
               lacc_in  = 32'd0;
               phase_in = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (!in_byte[7]) begin
               if (!rs[7]) begin
                  phase_in = PH_DELTA;
                  emit = 1'b1; kind = KIND_ERROR;
               end else if (rs >= 8'hC0 && rs < 8'hE0) begin
                  phase_in = PH_DELTA;
                  emit = 1'b1; kind = KIND_ONE_DATA; ev_status = rs; d1 = b7;
               end else begin
                  held_in = {1'b0, b7};
                  phase_in = PH_DATA2;
               end
            end else if (in_byte < 8'hF0) begin
               rs_in = in_byte;
               phase_in = PH_DATA1;
            end else begin
               rs_in = 8'd0; held_in = in_byte; meta_in = 8'd0;
               lacc_in = 32'd0; tacc_in = 24'd0;
               phase_in = (in_byte == 8'hF0 || in_byte == 8'hF7) ? PH_LEN : PH_TYPE;
            end
         end
         PH_DATA1: begin
            if (rs >= 8'hC0 && rs < 8'hE0) begin
               phase_in = PH_DELTA;
               emit = 1'b1; kind = KIND_ONE_DATA; ev_status = rs; d1 = b7;
            end else begin
               held_in = {1'b0, b7};
               phase_in = PH_DATA2;
            end
         end
         PH_DATA2: begin
            phase_in = PH_DELTA;
            emit = 1'b1; kind = KIND_TWO_DATA; ev_status = rs; d1 = held[6:0]; d2 = b7;
         end
         PH_TYPE: begin
            meta_in = in_byte;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            lacc_in = vlq;
            if (!in_byte[7]) begin
               prem_in = vlq;
               phase_in = (vlq == 32'd0) ? PH_DELTA : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (consumed < 32'd3) tacc_in = {tacc[15:0], in_byte};
            prem_in = prem - 32'd1;
         end
         PH_ENDED: begin
            emit = 1'b1; kind = KIND_ERROR;
         end
         default: phase_in = PH_DELTA;
      endcase
      // end of a sysex/meta payload
      if ((phase == PH_LEN && !in_byte[7] && vlq == 32'd0) ||
          (phase == PH_PAYLOAD && prem_in == 32'd0)) begin
         phase_in = PH_DELTA;
         if (held == 8'hFF && meta == 8'h51) begin
            emit = 1'b1; kind = KIND_TEMPO; ev_tempo = tacc_in;
         end else if (held == 8'hFF && meta == 8'h2F) begin
            phase_in = PH_ENDED;
            emit = 1'b1; kind = KIND_EOT;
         end
      end
   end

   assign ev_push = in_beat && in_range && emit;
   always_comb begin
      ev_data.kind   = kind;
      ev_data.track  = in_track;
      ev_data.status = ev_status;
      ev_data.data1  = d1;
      ev_data.data2  = d2;
      ev_data.tick   = tick_in;
      ev_data.tempo  = ev_tempo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TRACKS; i++) begin
            phase_ff[i] <= PH_DELTA; rs_ff[i] <= 8'd0; held_ff[i] <= 8'd0;
            lacc_ff[i] <= 32'd0; tick_ff[i] <= 32'd0; prem_ff[i] <= 32'd0;
            meta_ff[i] <= 8'd0; tacc_ff[i] <= 24'd0;
         end
      end else if (in_beat && in_range) begin
         phase_ff[idx] <= phase_in; rs_ff[idx] <= rs_in; held_ff[idx] <= held_in;
         lacc_ff[idx] <= lacc_in; tick_ff[idx] <= tick_in; prem_ff[idx] <= prem_in;
         meta_ff[idx] <= meta_in; tacc_ff[idx] <= tacc_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/mtep_fifo.sv
// Two-entry event queue between parser and back end.
`default_nettype none
module mtep_fifo
   import mtep_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  ev_type      push_data,
   input  wire logic   pop,
   output logic        not_empty,
   output logic        has_room,
   output ev_type      head
);
   ev_type     mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign not_empty = cnt_ff != 2'd0;
   assign has_room  = cnt_ff != 2'd2;
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/mtep_back.sv
// Back end: tick_mult divider and output register.
`default_nettype none
module mtep_back
   import mtep_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [DIV_W-1:0] division,
   input  wire logic             q_valid,
   input  ev_type                q_head,
   output logic                  q_pop,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output ev_type                out_ev,
   output logic [MULT_W-1:0]     out_mult
);
   typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_type;

   state_type          state_ff, state_in;
   ev_type             ev_ff, ev_in;
   logic [MULT_W-1:0]  mult_ff, mult_in, num_ff, num_in;
   logic [DIV_W-1:0]   rem_ff, rem_in, dvs;
   logic [DIV_W:0]     rem_sh;
   logic [4:0]         cnt_ff, cnt_in;
   logic               take;

   assign dvs       = (division == '0) ? DIV_W'(1) : division;
   assign rem_sh    = {rem_ff, num_ff[MULT_W-1]};
   assign out_valid = state_ff == S_OUT;
   assign out_ev    = ev_ff;
   assign out_mult  = mult_ff;
   assign take      = state_ff == S_IDLE || (state_ff == S_OUT && out_ready);
   assign q_pop     = take && q_valid;

   always_comb begin
      state_in = state_ff; ev_in = ev_ff; mult_in = mult_ff;
      num_in = num_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      case (state_ff)
         S_DIV: begin
            // restoring divide, one quotient bit per beat
            num_in = {num_ff[MULT_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, dvs}) begin
               rem_in = DIV_W'(rem_sh - {1'b0, dvs});
               mult_in = {mult_ff[MULT_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DIV_W-1:0];
               mult_in = {mult_ff[MULT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = S_OUT;
               if (mult_in == '0) mult_in = MULT_W'(1);
            end
         end
         S_OUT: if (out_ready) state_in = S_IDLE;
         S_IDLE: ;
         default: state_in = S_IDLE;
      endcase
      if (q_pop) begin
         ev_in = q_head;
         if (q_head.kind == KIND_TEMPO) begin
            num_in   = MULT_W'({q_head.tempo, 3'b000}) + MULT_W'({q_head.tempo, 1'b0});
            rem_in   = '0;
            mult_in  = '0;
            cnt_in   = 5'(MULT_W - 1);
            state_in = S_DIV;
         end else begin
            mult_in  = '0;
            state_in = S_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      ev_ff <= ev_in; mult_ff <= mult_in; num_ff <= num_in; rem_ff <= rem_in;
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= 5'd0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff < 5'(MULT_W))
      else $error("divider count out of range");
   a_tempo_mult: assert property (@(posedge clock) disable iff (reset)
      out_valid && ev_ff.kind == KIND_TEMPO |-> mult_ff != '0)
      else $error("tempo event with zero tick_mult");
   a_plain_mult: assert property (@(posedge clock) disable iff (reset)
      out_valid && ev_ff.kind != KIND_TEMPO |-> mult_ff == '0)
      else $error("tick_mult set on non-tempo event");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> !q_pop)
      else $error("queue popped during divide");
`endif
endmodule
`default_nettype wire
